// ===== rtl/mhpq_pkg.sv =====
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int CAPACITY = 128;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 8;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int SLOT_W   = $clog2(CAPACITY + 1);
    localparam int OP_W     = 4;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] RES_INSERT = 2'd0;
    localparam logic [1:0] RES_FULL   = 2'd1;
    localparam logic [1:0] RES_EMPTY  = 2'd2;
    localparam logic [1:0] RES_REMOVE = 2'd3;

    localparam logic [OP_W-1:0] OP_IDLE         = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD_INS     = 4'd1;
    localparam logic [OP_W-1:0] OP_RD_PARENT    = 4'd2;
    localparam logic [OP_W-1:0] OP_UP_ROOT      = 4'd3;
    localparam logic [OP_W-1:0] OP_UP_STEP      = 4'd4;
    localparam logic [OP_W-1:0] OP_RD_ROOT_TAIL = 4'd5;
    localparam logic [OP_W-1:0] OP_LOAD_RM      = 4'd6;
    localparam logic [OP_W-1:0] OP_RD_CHILD     = 4'd7;
    localparam logic [OP_W-1:0] OP_DN_STEP      = 4'd8;

    typedef struct packed {
        logic                     req_type;
        logic signed [WORD_W-1:0] value;
    } mhpq_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       entry_count;
    } mhpq_res_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            finish;
        logic [1:0]      res_sel;
    } mhpq_cmd_t;

    typedef struct packed {
        logic at_root;
        logic up_move;
        logic dn_move;
        logic full;
        logic empty;
    } mhpq_status_t;

endpackage

// ===== rtl/max_heap_priority_queue.sv =====
`timescale 1ns / 1ps

// Binary max-heap priority queue of signed 32-bit values held in one on-chip memory with two
// registered read ports. A request is transferred on a rising edge with start high and busy low;
// its result appears for exactly one cycle with done high, and the receiver cannot stall it. An
// insert on a full heap or a remove on an empty one is answered in the cycle after the transfer
// without raising busy. Otherwise busy stays high while the request walks the heap: an insert
// climbs from the new last slot toward the root, and a remove reads the root and the last entry,
// then sifts down from the root. Each level is a memory read followed by a compare-and-write
// step. Memory contents need no clearing after reset.
module max_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  mhpq_req_t req,
    output logic      done,
    output mhpq_res_t result
);

    mhpq_cmd_t    cmd;
    mhpq_status_t stat;

    mhpq_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    mhpq_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

// ===== rtl/mhpq_datapath.sv =====
`timescale 1ns / 1ps

module mhpq_datapath
    import mhpq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  mhpq_req_t    req,
    input  mhpq_cmd_t    cmd,
    output mhpq_status_t stat,
    output mhpq_res_t    result
);

    logic signed [WORD_W-1:0] mem [CAPACITY];

    logic [SLOT_W-1:0]        count_reg, count_next;
    logic [SLOT_W-1:0]        pos_reg, pos_next;
    logic signed [WORD_W-1:0] v_reg, v_next;
    logic signed [WORD_W-1:0] top_reg, top_next;
    logic signed [WORD_W-1:0] rd_a_reg, rd_b_reg;
    mhpq_res_t                result_reg, result_next;

    logic                     rd_en;
    logic [ADDR_W-1:0]        addr_a, addr_b;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [WORD_W-1:0] mem_wdata;

    logic [SLOT_W:0]          left_slot, right_slot;
    logic                     left_ok, right_ok, left_gt, right_gt;
    logic signed [WORD_W-1:0] best_val, child_val;
    logic [SLOT_W-1:0]        child_slot;

    always_comb
    begin
        left_slot  = {pos_reg, 1'b0};
        right_slot = left_slot + (SLOT_W + 1)'(1);
        left_ok    = left_slot <= {1'b0, count_reg};
        right_ok   = right_slot <= {1'b0, count_reg};
        left_gt    = left_ok && (rd_a_reg > v_reg);
        best_val   = left_gt ? rd_a_reg : v_reg;
        right_gt   = right_ok && (rd_b_reg > best_val);
        child_val  = right_gt ? rd_b_reg : rd_a_reg;
        child_slot = right_gt ? SLOT_W'(right_slot) : SLOT_W'(left_slot);
    end

    assign stat.at_root = pos_reg == SLOT_W'(1);
    assign stat.up_move = v_reg > rd_a_reg;
    assign stat.dn_move = left_gt || right_gt;
    assign stat.full    = count_reg == SLOT_W'(CAPACITY);
    assign stat.empty   = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        v_next     = v_reg;
        top_next   = top_reg;
        rd_en      = 1'b0;
        addr_a     = '0;
        addr_b     = '0;
        mem_we     = 1'b0;
        mem_waddr  = ADDR_W'(pos_reg - SLOT_W'(1));
        mem_wdata  = v_reg;
        unique case (cmd.op)
            OP_IDLE:
            begin
            end
            OP_LOAD_INS:
            begin
                v_next     = req.value;
                count_next = count_reg + SLOT_W'(1);
                pos_next   = count_reg + SLOT_W'(1);
            end
            OP_RD_PARENT:
            begin
                rd_en  = 1'b1;
                addr_a = ADDR_W'((pos_reg >> 1) - SLOT_W'(1));
            end
            OP_UP_ROOT:
            begin
                mem_we = 1'b1;
            end
            OP_UP_STEP:
            begin
                mem_we = 1'b1;
                if (stat.up_move)
                begin
                    mem_wdata = rd_a_reg;
                    pos_next  = pos_reg >> 1;
                end
            end
            OP_RD_ROOT_TAIL:
            begin
                rd_en  = 1'b1;
                addr_a = '0;
                addr_b = ADDR_W'(count_reg - SLOT_W'(1));
            end
            OP_LOAD_RM:
            begin
                top_next   = rd_a_reg;
                v_next     = rd_b_reg;
                pos_next   = SLOT_W'(1);
                count_next = count_reg - SLOT_W'(1);
            end
            OP_RD_CHILD:
            begin
                rd_en  = 1'b1;
                addr_a = ADDR_W'(left_slot - (SLOT_W + 1)'(1));
                addr_b = ADDR_W'(left_slot);
            end
            OP_DN_STEP:
            begin
                mem_we = 1'b1;
                if (stat.dn_move)
                begin
                    mem_wdata = child_val;
                    pos_next  = child_slot;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result_next             = result_reg;
        result_next.entry_count = COUNT_W'(count_next);
        unique case (cmd.res_sel)
            RES_INSERT:
            begin
                result_next.top_value = '0;
                result_next.status    = ST_DONE;
            end
            RES_FULL:
            begin
                result_next.top_value = '0;
                result_next.status    = ST_FULL;
            end
            RES_EMPTY:
            begin
                result_next.top_value = '1;
                result_next.status    = ST_EMPTY;
            end
            RES_REMOVE:
            begin
                result_next.top_value = top_reg;
                result_next.status    = ST_DONE;
            end
            default:
            begin
                result_next.top_value = '0;
                result_next.status    = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        v_reg   <= v_next;
        top_reg <= top_next;
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/mhpq_controller.sv =====
`timescale 1ns / 1ps

module mhpq_controller
    import mhpq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         req_type,
    input  mhpq_status_t stat,
    output mhpq_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_READ = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_RM_LOAD = 3'd3;
    localparam logic [2:0] S_DN_READ = 3'd4;
    localparam logic [2:0] S_DN_CMP  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       done_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = OP_IDLE;
        cmd.finish  = 1'b0;
        cmd.res_sel = RES_INSERT;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.finish  = 1'b1;
                            cmd.res_sel = RES_FULL;
                        end
                        else
                        begin
                            cmd.op     = OP_LOAD_INS;
                            state_next = S_UP_READ;
                        end
                    end
                    else if (stat.empty)
                    begin
                        cmd.finish  = 1'b1;
                        cmd.res_sel = RES_EMPTY;
                    end
                    else
                    begin
                        cmd.op     = OP_RD_ROOT_TAIL;
                        state_next = S_RM_LOAD;
                    end
                end
            end
            S_UP_READ:
            begin
                if (stat.at_root)
                begin
                    cmd.op      = OP_UP_ROOT;
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_INSERT;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_RD_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                cmd.op = OP_UP_STEP;
                if (stat.up_move)
                begin
                    state_next = S_UP_READ;
                end
                else
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_INSERT;
                    state_next  = S_IDLE;
                end
            end
            S_RM_LOAD:
            begin
                cmd.op     = OP_LOAD_RM;
                state_next = S_DN_READ;
            end
            S_DN_READ:
            begin
                cmd.op     = OP_RD_CHILD;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                cmd.op = OP_DN_STEP;
                if (stat.dn_move)
                begin
                    state_next = S_DN_READ;
                end
                else
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = RES_REMOVE;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

endmodule

// ===== rtl/mhpq_checker.sv =====
`timescale 1ns / 1ps

module mhpq_checker
    import mhpq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input mhpq_req_t req,
    input logic      done,
    input mhpq_res_t result
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still in progress");

    a_transfer_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("transferred request neither started nor answered");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without a request");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |->
            (result.top_value == -1 && result.entry_count == '0))
        else $error("empty remove result malformed");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |->
            (result.top_value == 0 && result.entry_count == COUNT_W'(CAPACITY)))
        else $error("dropped insert result malformed");

endmodule

bind max_heap_priority_queue mhpq_checker u_chk (.*);
